[src/mksr_pkg.sv]
// mksr_pkg: shared constants and types for the MIDI keyboard split router
// depends on nothing; imported by mksr_hold_mem, midi_keyboard_split_router and the bench
`default_nettype none

package mksr_pkg;

  // fixed sizes
  localparam int NOTE_RANGE = 128;
  localparam int NOTE_BITS  = $clog2(NOTE_RANGE);
  localparam int TOTAL_BITS = 8;
  localparam int COUNT_BITS_DEF = 8;

  // request opcodes
  localparam logic OP_MIDI  = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  // MIDI message types (upper nibble of status)
  localparam logic [3:0] MSG_NOTE_ON  = 4'h9;
  localparam logic [3:0] MSG_NOTE_OFF = 4'h8;

  // result route codes
  localparam logic [1:0] ROUTE_NONE   = 2'd0;
  localparam logic [1:0] ROUTE_CHORD  = 2'd1;
  localparam logic [1:0] ROUTE_MELODY = 2'd2;

  // sync event codes
  localparam logic [1:0] SYNC_NONE  = 2'd0;
  localparam logic [1:0] SYNC_START = 2'd1;
  localparam logic [1:0] SYNC_STOP  = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SPLIT_NOTE = 2'd0;
  localparam logic [1:0] CFG_FULL_KBD   = 2'd1;
  localparam logic [1:0] CFG_STOP_REL   = 2'd2;

  // write request into the hold counter store
  typedef struct packed {
    logic                 chord_we;
    logic                 melody_we;
    logic                 clear;
    logic [NOTE_BITS-1:0] addr;
  } mksr_wr_t;

endpackage

`default_nettype wire

[src/mksr_hold_mem.sv]
// mksr_hold_mem: per-note hold counters for the chord and melody zones
// depends on mksr_pkg; one memory per zone plus per-entry valid bits
`default_nettype none

module mksr_hold_mem
  import mksr_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire  [NOTE_BITS-1:0]  rd_addr,
  input  wire  mksr_wr_t        wr,
  input  wire  [COUNT_BITS-1:0] wr_data,
  output logic [COUNT_BITS-1:0] chord_cnt,
  output logic [COUNT_BITS-1:0] melody_cnt
);

  logic [COUNT_BITS-1:0] chord_mem  [NOTE_RANGE];
  logic [COUNT_BITS-1:0] melody_mem [NOTE_RANGE];
  logic [NOTE_RANGE-1:0] chord_vld_r;
  logic [NOTE_RANGE-1:0] melody_vld_r;
  logic [COUNT_BITS-1:0] chord_rd_r;
  logic [COUNT_BITS-1:0] melody_rd_r;
  logic [COUNT_BITS-1:0] fwd_data_r;
  logic                  chord_hit_r;
  logic                  melody_hit_r;
  logic [NOTE_BITS-1:0]  addr_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr.chord_we) begin
      chord_mem[wr.addr] <= wr_data;
    end
    if (wr.melody_we) begin
      melody_mem[wr.addr] <= wr_data;
    end
    chord_rd_r  <= chord_mem[rd_addr];
    melody_rd_r <= melody_mem[rd_addr];
  end

  // bypass for a read that meets a write to the same note
  always_ff @(posedge clk) begin
    addr_r       <= rd_addr;
    fwd_data_r   <= wr_data;
    chord_hit_r  <= wr.chord_we && (wr.addr == rd_addr);
    melody_hit_r <= wr.melody_we && (wr.addr == rd_addr);
  end

  // valid bits: reset and clear empty every entry at once
  always_ff @(posedge clk) begin
    if (!rst_n || wr.clear) begin
      chord_vld_r  <= '0;
      melody_vld_r <= '0;
    end else begin
      if (wr.chord_we) begin
        chord_vld_r[wr.addr] <= 1'b1;
      end
      if (wr.melody_we) begin
        melody_vld_r[wr.addr] <= 1'b1;
      end
    end
  end

  // effective counts; an entry never written reads as zero
  always_comb begin
    chord_cnt  = '0;
    melody_cnt = '0;
    if (chord_vld_r[addr_r]) begin
      chord_cnt = chord_hit_r ? fwd_data_r : chord_rd_r;
    end
    if (melody_vld_r[addr_r]) begin
      melody_cnt = melody_hit_r ? fwd_data_r : melody_rd_r;
    end
  end

endmodule

`default_nettype wire

[src/midi_keyboard_split_router.sv]
// midi_keyboard_split_router: top level, request decode, zone routing and sync tracking
// depends on mksr_pkg and mksr_hold_mem
//
//   channel   ports                                     handshake
//   request   start, busy, in_*                         start && !busy
//   result    out_valid, out_*                          one-cycle strobe, no stall
//   config    cfg_valid, cfg_ready, cfg_index, cfg_data cfg_valid && cfg_ready
//
// a request is accepted in any cycle; the input registers and the registered memory read load
// at the accept edge, and the result register loads at the next edge
// the input stage reads both zone counter memories, and the update stage then writes the
// counters and the result register, so the registered memory read sets when results appear
// busy and cfg_ready stay constant; a clear request empties all counters at once
// synchronous active-low reset restores config defaults and empties every counter
`default_nettype none

module midi_keyboard_split_router
  import mksr_pkg::*;
#(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  wire        in_opcode,
  input  wire  [7:0] in_status_byte,
  input  wire  [7:0] in_first_data,
  input  wire  [7:0] in_second_data,
  output logic       out_valid,
  output logic [1:0] out_route,
  output logic [7:0] out_status,
  output logic [7:0] out_first,
  output logic [7:0] out_second,
  output logic       out_note_held,
  output logic [7:0] out_chord_notes_held,
  output logic       out_count_changed,
  output logic [1:0] out_sync_event,
  input  wire        cfg_valid,
  output logic       cfg_ready,
  input  wire  [1:0] cfg_index,
  input  wire  [7:0] cfg_data
);

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  // config registers
  logic [6:0] split_r;
  logic       full_kbd_r;
  logic       stop_rel_r;

  // stage one registers
  logic       s1_vld_r;
  logic       s1_op_r;
  logic [7:0] s1_status_r;
  logic [7:0] s1_first_r;
  logic [7:0] s1_second_r;

  // block state
  logic [TOTAL_BITS-1:0] total_r;
  logic [TOTAL_BITS-1:0] total_nxt;
  logic                  sync_r;
  logic                  sync_nxt;

  // stage two combinational results
  logic [COUNT_BITS-1:0] chord_cnt;
  logic [COUNT_BITS-1:0] melody_cnt;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_new;
  logic [6:0]            note;
  logic [6:0]            vel;
  logic [3:0]            msg_type;
  logic                  is_note;
  logic                  is_chord;
  logic                  note_on;
  logic [1:0]            route_nxt;
  logic [7:0]            status_nxt;
  logic [7:0]            first_nxt;
  logic [7:0]            second_nxt;
  logic                  held_nxt;
  logic [1:0]            sync_ev_nxt;
  logic                  stop_hit;
  mksr_wr_t              wr;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      split_r    <= 7'd60;
      full_kbd_r <= 1'b0;
      stop_rel_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SPLIT_NOTE: split_r    <= cfg_data[6:0];
        CFG_FULL_KBD:   full_kbd_r <= cfg_data[0];
        CFG_STOP_REL:   stop_rel_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= start && !busy;
    end
    s1_op_r     <= in_opcode;
    s1_status_r <= in_status_byte;
    s1_first_r  <= in_first_data;
    s1_second_r <= in_second_data;
  end

  mksr_hold_mem #(
    .COUNT_BITS (COUNT_BITS)
  ) u_hold_mem (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_addr    (in_first_data[NOTE_BITS-1:0]),
    .wr         (wr),
    .wr_data    (cnt_new),
    .chord_cnt  (chord_cnt),
    .melody_cnt (melody_cnt)
  );

  // decode and zone select
  assign msg_type = s1_status_r[7:4];
  assign note     = s1_first_r[6:0];
  assign vel      = s1_second_r[6:0];
  assign is_note  = (msg_type == MSG_NOTE_ON) || (msg_type == MSG_NOTE_OFF);
  assign is_chord = (note <= split_r) || full_kbd_r;
  assign note_on  = (msg_type == MSG_NOTE_ON) && (vel != 7'd0);
  assign cnt      = is_chord ? chord_cnt : melody_cnt;

  // counter update, held total and sync tracking
  always_comb begin
    route_nxt   = ROUTE_NONE;
    status_nxt  = 8'd0;
    first_nxt   = 8'd0;
    second_nxt  = 8'd0;
    held_nxt    = 1'b0;
    sync_ev_nxt = SYNC_NONE;
    total_nxt   = total_r;
    sync_nxt    = sync_r;
    cnt_new     = cnt;
    wr          = '{chord_we: 1'b0, melody_we: 1'b0, clear: 1'b0, addr: note};
    stop_hit    = 1'b0;

    if (s1_vld_r) begin
      if (s1_op_r == OP_CLEAR) begin
        wr.clear  = 1'b1;
        total_nxt = '0;
        stop_hit  = 1'b1;
      end else if (!is_note) begin
        status_nxt = s1_status_r;
        first_nxt  = s1_first_r;
        second_nxt = s1_second_r;
      end else begin
        route_nxt    = is_chord ? ROUTE_CHORD : ROUTE_MELODY;
        status_nxt   = s1_status_r;
        first_nxt    = {1'b0, note};
        second_nxt   = {1'b0, vel};
        wr.chord_we  = is_chord;
        wr.melody_we = !is_chord;
        if (note_on) begin
          if (cnt == '0 && is_chord) begin
            total_nxt = total_r + TOTAL_BITS'(1);
          end
          if (cnt != CNT_MAX) begin
            cnt_new = cnt + COUNT_BITS'(1);
          end
          // first chord note held starts sync
          if (total_r == '0 && total_nxt != '0 && !sync_r) begin
            sync_nxt    = 1'b1;
            sync_ev_nxt = SYNC_START;
          end
        end else begin
          if (cnt != '0) begin
            cnt_new = cnt - COUNT_BITS'(1);
            if (cnt_new == '0 && is_chord && total_r != '0) begin
              total_nxt = total_r - TOTAL_BITS'(1);
            end
          end
          stop_hit = 1'b1;
        end
        held_nxt = (cnt_new != '0);
      end
      // last chord note released, or a clear, stops sync when stop on release is set
      if (stop_hit && stop_rel_r && total_r != '0 && total_nxt == '0 && sync_r) begin
        sync_nxt    = 1'b0;
        sync_ev_nxt = SYNC_STOP;
      end
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r   <= '0;
      sync_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      total_r   <= total_nxt;
      sync_r    <= sync_nxt;
      out_valid <= s1_vld_r;
    end
    out_route            <= route_nxt;
    out_status           <= status_nxt;
    out_first            <= first_nxt;
    out_second           <= second_nxt;
    out_note_held        <= held_nxt;
    out_chord_notes_held <= total_nxt;
    out_count_changed    <= (total_nxt != total_r);
    out_sync_event       <= sync_ev_nxt;
  end

`ifndef SYNTH
  // held total can never exceed the number of notes
  a_total_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_chord_notes_held <= TOTAL_BITS'(NOTE_RANGE)))
    else $error("chord_notes_held above note range");

  // a sync start always comes with a count change to nonzero
  a_start_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_sync_event == SYNC_START) |->
      out_count_changed && (out_chord_notes_held != 8'd0))
    else $error("sync start without count change");

  // a sync stop leaves no chord note held
  a_stop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_sync_event == SYNC_STOP) |-> (out_chord_notes_held == 8'd0))
    else $error("sync stop with notes held");

  // routed notes carry masked data bytes
  a_note_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_route != ROUTE_NONE) |-> !out_first[7] && !out_second[7])
    else $error("routed note data not masked");
`endif

endmodule

`default_nettype wire

[tb/tb_midi_keyboard_split_router.sv]
// tb_midi_keyboard_split_router: self-checking bench for the MIDI keyboard split router
// depends on mksr_pkg and midi_keyboard_split_router; predicts each result from its own
// model of zone routing, per-note hold counters and sync tracking
`default_nettype none

module tb_midi_keyboard_split_router;
  timeunit 1ns;
  timeprecision 1ps;

  import mksr_pkg::*;

  localparam int HOLD_MAX    = (1 << COUNT_BITS_DEF) - 1;
  localparam int CYCLE_LIMIT = 150000;
  localparam logic [1:0] CFG_SPARE = 2'd3;

  // one result as the block reports it
  typedef struct packed {
    logic [1:0] route;
    logic [7:0] status_b;
    logic [7:0] first_b;
    logic [7:0] second_b;
    logic       note_held;
    logic [7:0] chord_held;
    logic       count_changed;
    logic [1:0] sync_event;
  } midi_result_t;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_opcode;
  logic [7:0] in_status_byte;
  logic [7:0] in_first_data;
  logic [7:0] in_second_data;
  logic       out_valid;
  logic [1:0] out_route;
  logic [7:0] out_status;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic       out_note_held;
  logic [7:0] out_chord_notes_held;
  logic       out_count_changed;
  logic [1:0] out_sync_event;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [1:0] cfg_index;
  logic [7:0] cfg_data;

  // router state as predicted
  int         chord_counts [NOTE_RANGE];
  int         melody_counts [NOTE_RANGE];
  int         chord_total;
  bit         sync_on;
  logic [6:0] split_cfg;
  bit         full_kbd_cfg;
  bit         stop_rel_cfg;

  midi_result_t routed_results[$];
  int           error_count = 0;
  int           cycle_count = 0;
  int           burst_left;

  midi_keyboard_split_router uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_opcode            (in_opcode),
    .in_status_byte       (in_status_byte),
    .in_first_data        (in_first_data),
    .in_second_data       (in_second_data),
    .out_valid            (out_valid),
    .out_route            (out_route),
    .out_status           (out_status),
    .out_first            (out_first),
    .out_second           (out_second),
    .out_note_held        (out_note_held),
    .out_chord_notes_held (out_chord_notes_held),
    .out_count_changed    (out_count_changed),
    .out_sync_event       (out_sync_event),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_midi_keyboard_split_router failed");
      $finish;
    end
  end

  // stop rule shared by note-off and clear
  function automatic bit sync_stops(input int prev_total);
    if (stop_rel_cfg && prev_total != 0 && chord_total == 0 && sync_on) begin
      sync_on = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // route one request and update the predicted counters
  function automatic midi_result_t route_midi(input logic op, input logic [7:0] st,
                                              input logic [7:0] d1, input logic [7:0] d2);
    midi_result_t r;
    int           prev_total;
    int           cnt;
    logic [6:0]   note;
    logic [6:0]   vel;
    bit           chord;
    r = '0;
    prev_total = chord_total;
    if (op == OP_CLEAR) begin
      for (int i = 0; i < NOTE_RANGE; i++) begin
        chord_counts[i] = 0;
        melody_counts[i] = 0;
      end
      chord_total = 0;
      if (sync_stops(prev_total)) r.sync_event = SYNC_STOP;
    end else if (st[7:4] != MSG_NOTE_ON && st[7:4] != MSG_NOTE_OFF) begin
      r.status_b = st;
      r.first_b = d1;
      r.second_b = d2;
    end else begin
      note = d1[6:0];
      vel = d2[6:0];
      chord = (note <= split_cfg) || full_kbd_cfg;
      cnt = chord ? chord_counts[note] : melody_counts[note];
      r.route = chord ? ROUTE_CHORD : ROUTE_MELODY;
      r.status_b = st;
      r.first_b = {1'b0, note};
      r.second_b = {1'b0, vel};
      if (st[7:4] == MSG_NOTE_ON && vel != 7'd0) begin
        if (cnt == 0 && chord) chord_total++;
        if (cnt < HOLD_MAX) cnt++;
        if (prev_total == 0 && chord_total != 0 && !sync_on) begin
          sync_on = 1'b1;
          r.sync_event = SYNC_START;
        end
      end else begin
        if (cnt != 0) begin
          cnt--;
          if (cnt == 0 && chord && chord_total > 0) chord_total--;
        end
        if (sync_stops(prev_total)) r.sync_event = SYNC_STOP;
      end
      if (chord) chord_counts[note] = cnt;
      else melody_counts[note] = cnt;
      r.note_held = (cnt != 0);
    end
    r.chord_held = chord_total[7:0];
    r.count_changed = (prev_total != chord_total);
    return r;
  endfunction

  // result checker
  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    midi_result_t exp_r;
    if (rst_n && out_valid === 1'b1) begin
      if (routed_results.size() == 0) begin
        $display("%0t: unexpected result: expected none, got route %0h status %0h",
                 $time, out_route, out_status);
        error_count++;
      end else begin
        exp_r = routed_results.pop_front();
        check_field("route", 8'(exp_r.route), 8'(out_route));
        check_field("status", exp_r.status_b, out_status);
        check_field("first", exp_r.first_b, out_first);
        check_field("second", exp_r.second_b, out_second);
        check_field("note_held", 8'(exp_r.note_held), 8'(out_note_held));
        check_field("chord_notes_held", exp_r.chord_held, out_chord_notes_held);
        check_field("count_changed", 8'(exp_r.count_changed), 8'(out_count_changed));
        check_field("sync_event", 8'(exp_r.sync_event), 8'(out_sync_event));
      end
    end
  end

  // send one request, with bursts and random gaps in front
  task automatic send_request(input logic op, input logic [7:0] st,
                              input logic [7:0] d1, input logic [7:0] d2);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        start = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    start = 1'b1;
    in_opcode = op;
    in_status_byte = st;
    in_first_data = d1;
    in_second_data = d2;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    routed_results.insert(routed_results.size(), route_midi(op, st, d1, d2));
    burst_left--;
  endtask

  task automatic note_on(input logic [7:0] note, input logic [7:0] vel);
    send_request(OP_MIDI, {MSG_NOTE_ON, 4'($urandom)}, note, vel);
  endtask

  task automatic note_off(input logic [7:0] note);
    send_request(OP_MIDI, {MSG_NOTE_OFF, 4'($urandom)}, note, 8'($urandom));
  endtask

  // stop sending and let every outstanding result come back
  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (routed_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    case (idx)
      CFG_SPLIT_NOTE: split_cfg = data[6:0];
      CFG_FULL_KBD:   full_kbd_cfg = data[0];
      CFG_STOP_REL:   stop_rel_cfg = data[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // all three registers, unused upper bits filled with noise
  task automatic set_config(input logic [6:0] split, input bit full, input bit stop);
    drain_results();
    write_register(CFG_SPLIT_NOTE, {1'($urandom), split});
    write_register(CFG_FULL_KBD, {7'($urandom), full});
    write_register(CFG_STOP_REL, {7'($urandom), stop});
  endtask

  // routing, masking, pass-through and clear under reset defaults
  task automatic test_basic_routing();
    note_on(8'd60, 8'd100);
    note_on(8'd61, 8'h7F);
    send_request(OP_MIDI, 8'h9F, 8'hBC, 8'hFF);
    send_request(OP_MIDI, 8'h95, 8'd61, 8'h80);
    send_request(OP_MIDI, 8'h80, 8'd5, 8'h40);
    send_request(OP_MIDI, 8'hB0, 8'hFF, 8'hFF);
    send_request(OP_MIDI, 8'h00, 8'h00, 8'h00);
    send_request(OP_MIDI, 8'hFF, 8'h55, 8'hAA);
    send_request(OP_MIDI, 8'h8F, 8'd60, 8'hFF);
    note_off(8'd60);
    note_on(8'd0, 8'd1);
    send_request(OP_CLEAR, 8'hFF, 8'hFF, 8'hFF);
    send_request(OP_CLEAR, 8'h90, 8'd10, 8'd10);
  endtask

  // sync stops on last release and on clear, restarts on next chord note
  task automatic test_sync_stop();
    set_config(7'd60, 1'b0, 1'b1);
    note_on(8'd10, 8'd64);
    note_on(8'd11, 8'd64);
    note_off(8'd10);
    note_off(8'd11);
    note_on(8'd127, 8'd64);
    note_on(8'd11, 8'd64);
    send_request(OP_CLEAR, 8'h00, 8'h00, 8'h00);
  endtask

  // split at both ends, full-keyboard mode, and a write to the spare index
  task automatic test_split_extremes();
    set_config(7'd0, 1'b0, 1'b0);
    note_on(8'd0, 8'd20);
    note_on(8'd1, 8'd20);
    set_config(7'd127, 1'b0, 1'b0);
    note_on(8'd127, 8'd20);
    set_config(7'd0, 1'b1, 1'b0);
    write_register(CFG_SPARE, 8'hFF);
    note_on(8'd127, 8'd20);
    send_request(OP_CLEAR, 8'h5A, 8'hA5, 8'h3C);
  endtask

  // counters in both zones pushed past their maximum
  task automatic test_saturation();
    set_config(7'd60, 1'b0, 1'b1);
    for (int i = 0; i < HOLD_MAX + 2; i++) begin
      note_on(8'd30, 8'($urandom_range(1, 255)) | 8'd1);
      note_on(8'd90, 8'($urandom_range(1, 127)));
    end
    repeat (2) begin
      note_off(8'd30);
      note_off(8'd90);
    end
    send_request(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // mostly note traffic near the split point, some clears and noise
  task automatic random_request();
    int         pick;
    int         n;
    logic [7:0] d1;
    logic [7:0] d2;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 2) == 0) n = $urandom_range(0, 127);
    else n = int'(split_cfg) + int'($urandom_range(0, 8)) - 4;
    if (n < 0) n = 0;
    if (n > 127) n = 127;
    d1 = {1'($urandom), 7'(n)};
    if ($urandom_range(0, 9) == 0) d2 = {1'($urandom), 7'd0};
    else d2 = {1'($urandom), 7'($urandom_range(1, 127))};
    if (pick < 5)
      send_request(OP_CLEAR, 8'($urandom), 8'($urandom), 8'($urandom));
    else if (pick < 15)
      send_request(OP_MIDI, 8'($urandom), 8'($urandom), 8'($urandom));
    else if (pick < 58)
      send_request(OP_MIDI, {MSG_NOTE_ON, 4'($urandom)}, d1, d2);
    else
      send_request(OP_MIDI, {MSG_NOTE_OFF, 4'($urandom)}, d1, 8'($urandom));
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_config(7'd60, 1'b0, 1'b0);
        1: set_config(7'd0, 1'b0, 1'b1);
        2: set_config(7'd127, 1'b0, 1'b1);
        3: set_config(7'($urandom), 1'b1, 1'b1);
        4: set_config(7'($urandom), 1'b0, 1'b0);
        default: set_config(7'($urandom), 1'b0, 1'b1);
      endcase
      repeat (90) random_request();
    end
  endtask

  // reset, tests in turn, final verdict
  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = OP_MIDI;
    in_status_byte = 8'h00;
    in_first_data = 8'h00;
    in_second_data = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = CFG_SPLIT_NOTE;
    cfg_data = 8'h00;
    burst_left = 0;
    for (int i = 0; i < NOTE_RANGE; i++) begin
      chord_counts[i] = 0;
      melody_counts[i] = 0;
    end
    chord_total = 0;
    sync_on = 1'b0;
    split_cfg = 7'd60;
    full_kbd_cfg = 1'b0;
    stop_rel_cfg = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_basic_routing();
    test_sync_stop();
    test_split_extremes();
    test_saturation();
    test_random_traffic();
    drain_results();

    if (error_count == 0) begin
      $display("tb_midi_keyboard_split_router passed");
    end else begin
      $display("tb_midi_keyboard_split_router failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
